### hw/rtl/pcd6_pkg.sv
// ----------------------------------------------------------------------------
// pcd6_pkg: shared constants and types for the periodic central difference
// Holds default widths, line-length limits and the tag that travels with
// each stencil job from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package pcd6_pkg;

  localparam int DEFAULT_SAMPLE_WIDTH     = 24;
  localparam int DEFAULT_WEIGHT_FRAC_BITS = 18;

  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] LINE_LENGTH_RESET = 16'd64;
  localparam logic [COUNT_W-1:0] MIN_LINE_LENGTH   = 16'd7;

  // Six samples at the start of a line are kept for the wrap-around.
  localparam int HEAD_DEPTH = 6;
  localparam int TAPS       = 7;
  localparam int WRAP_LEN   = 12;

  // Extra results produced by the last item of a line.
  localparam logic [2:0] WRAP_JOBS = 3'd6;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COUNT_W-1:0] position;
    logic               line_done;
  } job_tag_t;

endpackage

### hw/rtl/periodic_central_difference_6th.sv
// ----------------------------------------------------------------------------
// periodic_central_difference_6th: streamed periodic sixth-order derivative
// Takes one line of samples in order and returns the seven-point central
// difference for every position, wrapping round at the ends of the line.
// ----------------------------------------------------------------------------
//
//   port group     dir   handshake              payload
//   -------------  ----  ---------------------  --------------------------------
//   input items    in    in_valid / in_stall    sample
//   result items   out   out_valid / out_stall  derivative, position, line_done
//   line length    in    cfg_write_en           cfg_write_data
//
// One item is taken per cycle while in_stall is low. An item at position
// six or later is written into the queue at the edge that accepts it; its
// job then loads the product stage and then the output register. The last
// item of a line holds the front end while it issues the six wrap-around
// results. Reset is synchronous and clears the position count, the queue
// and the pipeline valids; the line length returns to 64. A stall on the
// result side freezes the back end; the two-entry queue fills and then the
// input side is stalled as well.
//
module periodic_central_difference_6th
  #(
  parameter int SAMPLE_WIDTH     = pcd6_pkg::DEFAULT_SAMPLE_WIDTH,
  parameter int WEIGHT_FRAC_BITS = pcd6_pkg::DEFAULT_WEIGHT_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [pcd6_pkg::COUNT_W-1:0]   cfg_write_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] derivative,
  output logic [pcd6_pkg::COUNT_W-1:0]   position,
  output logic                           line_done
);
  import pcd6_pkg::*;

  localparam int TAG_W = $bits(job_tag_t);
  localparam int JOB_W = TAPS * SAMPLE_WIDTH + TAG_W;

  // Line length register; the user must write it only while the block is idle, which the block does not enforce.
  logic [COUNT_W-1:0] line_length;

  // Front end to queue.
  logic                                push;
  logic [TAPS-1:0][SAMPLE_WIDTH-1:0]   push_taps;
  job_tag_t                            push_tag;
  logic                                queue_full;
  logic                                front_busy;

  // Queue to back end.
  logic                                job_valid;
  logic [JOB_W-1:0]                    job_data;
  logic [TAPS-1:0][SAMPLE_WIDTH-1:0]   job_taps;
  job_tag_t                            job_tag;
  logic                                take;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LINE_LENGTH_RESET;
    end else if (cfg_write_en) begin
      line_length <= cfg_write_data;
    end
  end

  // The front end owns the window, the head of the line and the position
  // count. It stalls the input while wrap-around jobs are being issued or
  // while the queue is full.
  pcd6_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .line_length (line_length),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .queue_full  (queue_full),
    .push        (push),
    .taps        (push_taps),
    .tag         (push_tag),
    .busy        (front_busy)
  );

  // Each job carries the seven taps of one stencil together with its tag.
  pcd6_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_taps, push_tag}),
    .full       (queue_full),
    .take       (take),
    .head_valid (job_valid),
    .head_data  (job_data)
  );

  assign job_taps = job_data[JOB_W-1:TAG_W];
  assign job_tag  = job_data[TAG_W-1:0];

  // The back end weighs, sums, rounds and saturates, and holds each result
  // until the consumer takes it.
  pcd6_back #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .taps       (job_taps),
    .tag        (job_tag),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .derivative (derivative),
    .position   (position),
    .line_done  (line_done)
  );

  // While wrap-around jobs are issued no new item may enter.
  assert property (@(posedge clk) disable iff (rst) front_busy |-> in_stall)
    else $error("item intake open during wrap-around");

  // The front end never offers a job to a full queue during intake.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !queue_full)
    else $error("item accepted with the queue full");

  // The line's closing result always belongs to position 2.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_done) |-> (position == COUNT_W'(2)))
    else $error("line end flagged on a position other than 2");

  // A held result does not change while the consumer stalls.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(derivative) && $stable(position)))
    else $error("result changed under stall");

endmodule

### hw/rtl/pcd6_front.sv
// ----------------------------------------------------------------------------
// pcd6_front: item intake and job sequencing
// Keeps the sliding window, the head of the line and the position count,
// and issues one stencil job per item from position six on, plus six wrap-around jobs at line end.
// ----------------------------------------------------------------------------
module pcd6_front #(
  parameter int SAMPLE_WIDTH = pcd6_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [pcd6_pkg::COUNT_W-1:0]        line_length,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  logic                                queue_full,
  output logic                                push,
  output logic [pcd6_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0] taps,
  output pcd6_pkg::job_tag_t                  tag,
  output logic                                busy
);
  import pcd6_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] window [HEAD_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] head [HEAD_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] wrap_line [WRAP_LEN];
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] wrap_base;
  logic [2:0]         wrap_k;
  logic               wrapping;

  logic               accept;
  logic               has_result;
  logic               line_end;
  logic [COUNT_W-1:0] eff_len;
  logic [COUNT_W:0]   count_plus;

  assign eff_len    = (line_length < MIN_LINE_LENGTH) ? MIN_LINE_LENGTH : line_length;
  assign count_plus = {1'b0, count} + (COUNT_W+1)'(1);
  assign line_end   = count_plus >= {1'b0, eff_len};
  assign has_result = count >= COUNT_W'(HEAD_DEPTH);

  assign in_stall = wrapping || queue_full;
  assign accept   = in_valid && !in_stall;
  assign busy     = wrapping;
  assign push     = (accept && has_result) || (wrapping && !queue_full);

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      if (wrapping) begin
        taps[i] = wrap_line[i];
      end else if (i < HEAD_DEPTH) begin
        taps[i] = window[i];
      end else begin
        taps[i] = sample;
      end
    end
    if (!wrapping) begin
      tag.position  = count - COUNT_W'(3);
      tag.line_done = 1'b0;
    end else if (wrap_k <= 3'd3) begin
      tag.position  = wrap_base + COUNT_W'(wrap_k) - COUNT_W'(3);
      tag.line_done = 1'b0;
    end else begin
      tag.position  = COUNT_W'(wrap_k) - COUNT_W'(4);
      tag.line_done = (wrap_k == WRAP_JOBS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wrapping <= 1'b0;
      wrap_k   <= '0;
    end else if (accept) begin
      if (has_result && line_end) begin
        count    <= '0;
        wrapping <= 1'b1;
        wrap_k   <= 3'd1;
      end else begin
        count <= count_plus[COUNT_W-1:0];
      end
    end else if (wrapping && !queue_full) begin
      wrap_k <= wrap_k + 3'd1;
      if (wrap_k == WRAP_JOBS) begin
        wrapping <= 1'b0;
      end
    end
  end

  // Sample stores carry no reset; entries are always written before use.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!has_result) begin
        head[count[2:0]] <= sample;
      end
      for (int i = 0; i < HEAD_DEPTH - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[HEAD_DEPTH-1] <= sample;
      if (has_result && line_end) begin
        wrap_base <= count;
        for (int i = 0; i < HEAD_DEPTH - 1; i++) begin
          wrap_line[i] <= window[i+1];
        end
        wrap_line[HEAD_DEPTH-1] <= sample;
        for (int i = 0; i < HEAD_DEPTH; i++) begin
          wrap_line[HEAD_DEPTH+i] <= head[i];
        end
      end
    end else if (wrapping && !queue_full) begin
      for (int i = 0; i < WRAP_LEN - 1; i++) begin
        wrap_line[i] <= wrap_line[i+1];
      end
    end
  end

endmodule

### hw/rtl/pcd6_queue.sv
// ----------------------------------------------------------------------------
// pcd6_queue: short job queue between front and back end
// A two-entry register FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
module pcd6_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             take,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  import pcd6_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = fill == CNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/pcd6_back.sv
// ----------------------------------------------------------------------------
// pcd6_back: stencil arithmetic pipeline
// Stage one forms the three differences and their weighted products; stage
// two sums, rounds half up, saturates and holds the result for the consumer.
// ----------------------------------------------------------------------------
module pcd6_back #(
  parameter int SAMPLE_WIDTH     = pcd6_pkg::DEFAULT_SAMPLE_WIDTH,
  parameter int WEIGHT_FRAC_BITS = pcd6_pkg::DEFAULT_WEIGHT_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  logic [pcd6_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0] taps,
  input  pcd6_pkg::job_tag_t                  tag,
  output logic                                take,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      derivative,
  output logic [pcd6_pkg::COUNT_W-1:0]        position,
  output logic                                line_done
);
  import pcd6_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int DW   = SW + 1;
  localparam int PW   = DW + F + 1;
  localparam int SUMW = PW + 2;
  localparam int QW   = SUMW - F;

  // Weights in Q0.F, each rounded to nearest.
  localparam longint W_SIXTIETH_L = ((longint'(1) << F) + 30) / 60;
  localparam longint W_3_20TH_L   = ((longint'(3) << F) + 10) / 20;
  localparam longint W_3_4TH_L    = ((longint'(3) << F) + 2) / 4;
  localparam logic signed [F:0] W_SIXTIETH = (F+1)'(W_SIXTIETH_L);
  localparam logic signed [F:0] W_3_20TH   = (F+1)'(W_3_20TH_L);
  localparam logic signed [F:0] W_3_4TH    = (F+1)'(W_3_4TH_L);

  localparam logic signed [SUMW-1:0] HALF = SUMW'(longint'(1) << (F - 1));
  localparam logic signed [QW-1:0] QMAX = QW'((longint'(1) << (SW - 1)) - 1);
  localparam logic signed [QW-1:0] QMIN = QW'(-(longint'(1) << (SW - 1)));

  logic signed [DW-1:0] d_far;
  logic signed [DW-1:0] d_mid;
  logic signed [DW-1:0] d_near;
  logic signed [PW-1:0] p_far_next;
  logic signed [PW-1:0] p_mid_next;
  logic signed [PW-1:0] p_near_next;

  logic                 a_valid;
  job_tag_t             a_tag;
  logic signed [PW-1:0] p_far;
  logic signed [PW-1:0] p_mid;
  logic signed [PW-1:0] p_near;

  logic signed [SUMW-1:0] sum_r;
  logic signed [QW-1:0]   q;
  logic signed [SW-1:0]   sat;

  assign take = !out_valid || !out_stall;

  always_comb begin
    d_far  = DW'($signed(taps[6])) - DW'($signed(taps[0]));
    d_mid  = DW'($signed(taps[1])) - DW'($signed(taps[5]));
    d_near = DW'($signed(taps[4])) - DW'($signed(taps[2]));
    p_far_next  = PW'(d_far) * PW'(W_SIXTIETH);
    p_mid_next  = PW'(d_mid) * PW'(W_3_20TH);
    p_near_next = PW'(d_near) * PW'(W_3_4TH);
  end

  always_comb begin
    sum_r = SUMW'(p_far) + SUMW'(p_mid) + SUMW'(p_near) + HALF;
    q     = $signed(sum_r[SUMW-1:F]);
    if (q > QMAX) begin
      sat = QMAX[SW-1:0];
    end else if (q < QMIN) begin
      sat = QMIN[SW-1:0];
    end else begin
      sat = q[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (take) begin
      a_valid   <= job_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (job_valid) begin
        a_tag  <= tag;
        p_far  <= p_far_next;
        p_mid  <= p_mid_next;
        p_near <= p_near_next;
      end
      if (a_valid) begin
        derivative <= sat;
        position   <= a_tag.position;
        line_done  <= a_tag.line_done;
      end
    end
  end

endmodule

### verif/periodic_central_difference_6th_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_central_difference_6th_test: self-checking bench for the block
// Streams lines of grid samples through the block with random gaps on the
// input side and random stalls on the result side. A predictor mirrors the
// line state and works out every derivative, position and end-of-line flag,
// which are checked in order against the results that the block hands out.
// ----------------------------------------------------------------------------
module periodic_central_difference_6th_test;
  import pcd6_pkg::*;

  localparam int SW   = DEFAULT_SAMPLE_WIDTH;
  localparam int FRAC = DEFAULT_WEIGHT_FRAC_BITS;

  // Stencil weights in Q0.FRAC, each rounded to nearest.
  localparam longint W_SIXTIETH         = ((longint'(1) << FRAC) + 30) / 60;
  localparam longint W_THREE_TWENTIETHS = ((longint'(3) << FRAC) + 10) / 20;
  localparam longint W_THREE_QUARTERS   = ((longint'(3) << FRAC) + 2) / 4;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t SAMPLE_TOP    = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SW-1){1'b0}}};

  // Settling time after the last result before the line length is touched:
  // queue, product stage and output register, plus the six wrap-around jobs.
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 200;

  typedef struct packed {
    logic [SW-1:0]      derivative;
    logic [COUNT_W-1:0] position;
    logic               line_done;
  } derivative_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [COUNT_W-1:0] cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sample_t            sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sample_t            derivative;
  logic [COUNT_W-1:0] position;
  logic               line_done;

  periodic_central_difference_6th dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .derivative     (derivative),
    .position       (position),
    .line_done      (line_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be offered, and the results the predictor still owes.
  sample_t     samples_to_send [$];
  derivative_t expected_derivatives [$];

  // Predictor copy of the block state. The line length is the value most
  // recently written, or the reset value of 64.
  logic [COUNT_W-1:0] line_len = LINE_LENGTH_RESET;
  longint             head_store [0:HEAD_DEPTH-1];
  longint             recent_store [0:HEAD_DEPTH-1];
  int                 sample_pos = 0;

  // Seven taps around one position, extended by the head of the line so
  // that the wrap-around positions can be read off the same array.
  longint             extended_line [0:WRAP_LEN];

  // Planning side: where the next queued item will land in its line.
  int                 plan_pos = 0;
  int                 sent_total = 0;

  bit                 steady_flow = 1'b0;
  int                 send_gap = 0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;
  int                 error_count = 0;

  function automatic int effective_length();
    return (line_len < MIN_LINE_LENGTH) ? int'(MIN_LINE_LENGTH) : int'(line_len);
  endfunction

  // Mostly no gap, sometimes a few cycles, now and then a long pause. In a
  // steady stretch there are no gaps at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_TOP;
      1:       return SAMPLE_BOTTOM;
      2, 3:    return sample_t'(int'($urandom_range(0, 1023)) - 512);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // The derivative centred on extended_line[first + 3], rounded half up and
  // saturated. The sum of the three weighted differences is exact in 64 bits.
  function automatic sample_t stencil_at(input int first);
    longint acc;
    longint r;
    acc = (extended_line[first+6] - extended_line[first])   * W_SIXTIETH
        + (extended_line[first+1] - extended_line[first+5]) * W_THREE_TWENTIETHS
        + (extended_line[first+4] - extended_line[first+2]) * W_THREE_QUARTERS;
    r = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (r > longint'(SAMPLE_TOP)) r = longint'(SAMPLE_TOP);
    if (r < longint'(SAMPLE_BOTTOM)) r = longint'(SAMPLE_BOTTOM);
    return sample_t'(r);
  endfunction

  function automatic void owe_derivative(input sample_t d, input int pos, input bit done);
    derivative_t e;
    e.derivative = d;
    e.position   = pos[COUNT_W-1:0];
    e.line_done  = done;
    expected_derivatives.push_back(e);
  endfunction

  // Advances the predictor by one accepted item and records the results it
  // causes: nothing for the first six positions, one derivative from the
  // seventh on, and on the last item of the line the three trailing
  // positions followed by positions 0 to 2 through the wrap-around.
  function automatic void predict_derivatives(input sample_t x);
    int     c;
    int     k;
    int     pos;
    longint xv;
    xv = longint'(x);
    c  = sample_pos;
    if (c < HEAD_DEPTH) head_store[c] = xv;
    for (k = 0; k < HEAD_DEPTH; k++) extended_line[k] = recent_store[k];
    extended_line[HEAD_DEPTH] = xv;
    for (k = 0; k < HEAD_DEPTH - 1; k++) recent_store[k] = recent_store[k+1];
    recent_store[HEAD_DEPTH-1] = xv;
    if (c >= HEAD_DEPTH) begin
      owe_derivative(stencil_at(0), c - 3, 1'b0);
      // A length lowered below the current position ends the line here.
      if (c + 1 >= effective_length()) begin
        for (k = 0; k < HEAD_DEPTH; k++) extended_line[TAPS+k] = head_store[k];
        for (k = 4; k <= 9; k++) begin
          pos = (k <= 6) ? c - 3 + (k - 3) : k - 7;
          owe_derivative(stencil_at(k - 3), pos, k == 9);
        end
        sample_pos = 0;
        return;
      end
    end
    sample_pos = (c + 1) % (1 << COUNT_W);
  endfunction

  // Queues one item and follows its position in the line on the planning
  // side. Returns 1 when this item closes the line.
  function automatic bit plan_sample(input sample_t s);
    samples_to_send.push_back(s);
    sent_total++;
    if (plan_pos >= HEAD_DEPTH && plan_pos + 1 >= effective_length()) begin
      plan_pos = 0;
      return 1'b1;
    end
    plan_pos++;
    return 1'b0;
  endfunction

  function automatic void queue_random(input int count, input bit to_line_end);
    int i;
    bit ended;
    i = 0;
    ended = 1'b0;
    while (to_line_end ? !ended : i < count) begin
      ended = plan_sample(pick_sample());
      i++;
    end
  endfunction

  // Holds until every queued item has gone in and every result has come
  // out, then lets the pipeline settle. Polled on the falling edge so that
  // nothing here races the clocked driver and monitor.
  task automatic wait_idle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || expected_derivatives.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [COUNT_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    line_len = value;
    @(negedge clk);
  endtask

  // Driver: offers the next queued item once the current one is taken,
  // with a random gap after each item. A stalled item is held unchanged.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) send_gap = pick_gap();
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (samples_to_send.size() != 0) begin
        sample   <= samples_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: feeds every accepted item to the predictor first, so that an
  // expectation always exists before its result could be compared, then
  // checks every accepted result and decides the next stall.
  always @(posedge clk) begin
    derivative_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_derivatives(sample);
      if (out_valid && !out_stall) begin
        if (expected_derivatives.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected: derivative %0d position %0d",
                   $time, derivative, position);
        end else begin
          e = expected_derivatives.pop_front();
          if (derivative !== e.derivative) begin
            error_count++;
            $display("%0t: derivative at position %0d expected %0d actual %0d",
                     $time, e.position, $signed(e.derivative), derivative);
          end
          if (position !== e.position) begin
            error_count++;
            $display("%0t: position expected %0d actual %0d", $time, e.position, position);
          end
          if (line_done !== e.line_done) begin
            error_count++;
            $display("%0t: line_done at position %0d expected %0b actual %0b",
                     $time, e.position, e.line_done, line_done);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: ends the run when neither side moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_central_difference_6th verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    int kind;
    for (i = 0; i < HEAD_DEPTH; i++) begin
      head_store[i]   = 0;
      recent_store[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // One whole line at the reset length, before the register is touched.
    queue_random(0, 1'b1);

    // Directed part. Alternating full-scale samples drive the stencil into
    // saturation on both sides, with no idling on the input side.
    write_length(MIN_LINE_LENGTH);
    steady_flow = 1'b1;
    for (i = 0; i < 7; i++) void'(plan_sample(i % 2 ? SAMPLE_BOTTOM : SAMPLE_TOP));
    wait_idle();
    steady_flow = 1'b0;

    // A length of zero acts as the shortest line; tiny samples exercise
    // the rounding of small sums.
    write_length('0);
    for (i = 0; i < 7; i++) void'(plan_sample(sample_t'((i % 3) - 1)));

    // Longest length, then lowered mid-line: the next item ends the line
    // at its own position.
    write_length({COUNT_W{1'b1}});
    queue_random(10, 1'b0);
    write_length(MIN_LINE_LENGTH);
    queue_random(0, 1'b1);

    // Random part: whole lines of mostly short lengths, lengths below the
    // minimum, lengths cut short mid-line, and pauses with no change.
    while (sent_total < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      steady_flow = ($urandom_range(0, 4) == 0);
      if (kind <= 5) begin
        write_length(COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(25, 48)
                                                          : $urandom_range(7, 16)));
        queue_random(0, 1'b1);
        if ($urandom_range(0, 1) == 0) queue_random(0, 1'b1);
      end else if (kind == 6) begin
        write_length(COUNT_W'($urandom_range(0, 6)));
        queue_random(0, 1'b1);
      end else if (kind <= 8) begin
        write_length(($urandom_range(0, 1) == 0) ? {COUNT_W{1'b1}}
                                                 : COUNT_W'($urandom_range(50, 65534)));
        queue_random($urandom_range(1, 24), 1'b0);
        write_length(COUNT_W'($urandom_range(0, 30)));
        queue_random(0, 1'b1);
      end else begin
        // The sender holds mid-line until every owed result is out.
        queue_random($urandom_range(1, 12), 1'b0);
        wait_idle();
        queue_random(0, 1'b1);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("periodic_central_difference_6th verification clean");
    end else begin
      $display("periodic_central_difference_6th verification failed");
    end
    $finish;
  end

endmodule
